[src/spectral_flux_onset_detector_unit_macros.svh]
// assertion macros used by the onset detector top level
`ifndef SPECTRAL_FLUX_ONSET_DETECTOR_UNIT_MACROS_SVH
`define SPECTRAL_FLUX_ONSET_DETECTOR_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define SFOD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SFOD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/sfod_pkg.sv]
// shared constants and types of the onset detector
`timescale 1ns / 1ps
package sfod_pkg;

  localparam int MAX_BINS_DEF = 4096;

  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] REG_ONSET_ENABLE    = 3'd0;
  localparam logic [CFG_IW-1:0] REG_GROUP_BINS      = 3'd1;
  localparam logic [CFG_IW-1:0] REG_THRESHOLD_LOW   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_THRESHOLD_SCALE = 3'd3;

  localparam logic [12:0] GROUP_BINS_RST = 13'd47;
  localparam logic [15:0] ONE_Q15 = 16'd32768;

  localparam int DVD_W = 64;
  localparam int DSR_W = 48;
  localparam logic signed [55:0] FLUX_MAX = 56'sh7F_FFFF_FFFF_FFFF;
  localparam logic signed [55:0] FLUX_MIN = 56'sh80_0000_0000_0000;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

[src/sfod_mem.sv]
// previous-frame magnitude store, one write and one registered read port
`timescale 1ns / 1ps
module sfod_mem #(
  parameter int DEPTH = sfod_pkg::MAX_BINS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [31:0]              wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [31:0]              rdata
);
  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[src/sfod_div.sv]
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module sfod_div (
  input  logic               clk,
  input  logic               rst,
  input  sfod_pkg::div_req_t req,
  output sfod_pkg::div_rsp_t rsp
);
  import sfod_pkg::*;

  localparam int CW = $clog2(DVD_W);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DVD_W-1:0] dvd;
  logic [DSR_W:0]   rem;
  logic [DSR_W-1:0] dsr;
  logic             done;
  logic [DSR_W:0]   rem_sh;
  logic [DSR_W:0]   rem_sub;
  logic             fits;

  always_comb begin
    rem_sh  = {rem[DSR_W-1:0], dvd[DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dsr};
    fits    = rem_sh >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= req.dividend;
        dsr  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        // quotient bits shift in where dividend bits leave
        rem <= fits ? rem_sub : rem_sh;
        dvd <= {dvd[DVD_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dvd;
endmodule

[src/spectral_flux_onset_detector_unit.sv]
// top level of the spectral flux onset detector
//
//  channel  signals                                    direction
//  in       in_valid/in_ready, magnitude, last_bin     into block
//  out      out_valid/out_ready, onset_strength        out of block
//  cfg      cfg_valid/cfg_ready, cfg_index, cfg_data   into block
//
// a bin is accepted in S_IDLE with the store read, then updated and written back in S_RD
// a bin that closes a group then waits in S_DIV for the bit-serial divider
// a last bin then passes S_LAST, S_STR and S_MUL for the flux add, threshold and 32x32 multiply
// after reset a clearing pass zeroes every store address, no bin taken
// a held result stalls the next last bin only at its final step
`timescale 1ns / 1ps
`include "spectral_flux_onset_detector_unit_macros.svh"
module spectral_flux_onset_detector_unit #(
  parameter int MAX_BINS = sfod_pkg::MAX_BINS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [31:0]                 magnitude,
  input  logic                        last_bin,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [15:0]                 onset_strength,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sfod_pkg::CFG_IW-1:0] cfg_index,
  input  logic [31:0]                 cfg_data
);
  import sfod_pkg::*;

  localparam int AW = $clog2(MAX_BINS);
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_BINS - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD, S_DIV, S_LAST, S_STR, S_MUL, S_OUT
  } state_t;

  state_t             state;
  logic [AW-1:0]      clr_addr;
  logic [AW-1:0]      bin_index;
  logic [12:0]        group_count;
  logic signed [47:0] rise_sum;
  logic [47:0]        base_sum;
  logic signed [55:0] flux_sum;
  logic [31:0]        mag_r;
  logic               last_r;
  logic               div_neg;
  logic [31:0]        diff_lo;
  logic               res_zero;
  logic               res_full;
  logic [63:0]        prod;

  logic        onset_enable;
  logic [12:0] group_bins;
  logic [31:0] threshold_low;
  logic [31:0] threshold_scale;

  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0] mem_wdata;
  logic [31:0] rd_data;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  logic signed [32:0] bin_rise;
  logic signed [48:0] rise_wide;
  logic signed [47:0] rise_new;
  logic [48:0]        base_wide;
  logic [47:0]        base_new;
  logic [47:0]        rise_abs;
  logic               group_hit;
  logic signed [55:0] q_sat;
  logic signed [55:0] q_signed;
  logic [54:0]        os;
  logic [54:0]        os_diff;
  logic [15:0]        strength;

  function automatic logic signed [55:0] flux_add(input logic signed [55:0] a,
                                                  input logic signed [55:0] v);
    logic signed [56:0] s;
    s = {a[55], a} + {v[55], v};
    if (s[56] != s[55]) begin
      flux_add = s[56] ? FLUX_MIN : FLUX_MAX;
    end else begin
      flux_add = s[55:0];
    end
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  sfod_mem #(.DEPTH(MAX_BINS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_valid && in_ready),
    .raddr (bin_index),
    .rdata (rd_data)
  );

  sfod_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    bin_rise  = $signed({1'b0, mag_r}) - $signed({1'b0, rd_data});
    rise_wide = {rise_sum[47], rise_sum} + {{16{bin_rise[32]}}, bin_rise};
    if (rise_wide[48] != rise_wide[47]) begin
      rise_new = rise_wide[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
    end else begin
      rise_new = rise_wide[47:0];
    end
    base_wide = {1'b0, base_sum} + {17'b0, rd_data};
    base_new  = base_wide[48] ? '1 : base_wide[47:0];
    rise_abs  = rise_new[47] ? 48'(-rise_new) : rise_new;
    group_hit = group_count >= group_bins;

    div_req.start    = (state == S_RD) && group_hit;
    div_req.dividend = {rise_abs, 16'b0};
    div_req.divisor  = base_new;

    // quotient saturates to the positive flux limit before the sign goes back on
    q_sat    = (div_rsp.quotient > 64'(FLUX_MAX)) ? FLUX_MAX : $signed(div_rsp.quotient[55:0]);
    q_signed = div_neg ? -q_sat : q_sat;

    os      = flux_sum[55] ? '0 : flux_sum[54:0];
    os_diff = os - {23'b0, threshold_low};

    if (res_zero) begin
      strength = '0;
    end else if (res_full || (prod[63:17] > 47'(ONE_Q15))) begin
      strength = ONE_Q15;
    end else begin
      strength = prod[32:17];
    end

    mem_we    = (state == S_CLEAR) || (state == S_RD);
    mem_waddr = (state == S_CLEAR) ? clr_addr : bin_index;
    mem_wdata = (state == S_CLEAR) ? 32'b0 : mag_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      onset_enable    <= 1'b0;
      group_bins      <= GROUP_BINS_RST;
      threshold_low   <= '0;
      threshold_scale <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ONSET_ENABLE:    onset_enable    <= cfg_data[0];
        REG_GROUP_BINS:      group_bins      <= cfg_data[12:0];
        REG_THRESHOLD_LOW:   threshold_low   <= cfg_data;
        REG_THRESHOLD_SCALE: threshold_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      bin_index   <= '0;
      group_count <= '0;
      rise_sum    <= '0;
      base_sum    <= 48'd1;
      flux_sum    <= '0;
      out_valid   <= 1'b0;
    end else begin
      // the result register is reloaded in S_OUT, cleared elsewhere once out_ready takes it
      if (out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            mag_r  <= magnitude;
            last_r <= last_bin;
            state  <= S_RD;
          end
        end
        S_RD: begin
          base_sum  <= base_new;
          bin_index <= (bin_index == LAST_IDX) ? '0 : bin_index + 1'b1;
          if (group_hit) begin
            rise_sum    <= '0;
            group_count <= 13'd1;
            div_neg     <= rise_new[47];
            state       <= S_DIV;
          end else begin
            rise_sum    <= rise_new;
            group_count <= group_count + 1'b1;
            state       <= last_r ? S_LAST : S_IDLE;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            flux_sum <= flux_add(flux_sum, q_signed);
            state    <= last_r ? S_LAST : S_IDLE;
          end
        end
        S_LAST: begin
          flux_sum <= flux_add(flux_sum, {{8{rise_sum[47]}}, rise_sum});
          state    <= S_STR;
        end
        S_STR: begin
          res_zero <= !onset_enable || (os <= {23'b0, threshold_low})
                      || (threshold_scale == '0);
          res_full <= os_diff[54:32] != '0;
          diff_lo  <= os_diff[31:0];
          state    <= S_MUL;
        end
        S_MUL: begin
          prod  <= diff_lo * threshold_scale;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            onset_strength <= strength;
            bin_index      <= '0;
            group_count    <= '0;
            rise_sum       <= '0;
            base_sum       <= 48'd1;
            flux_sum       <= '0;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SFOD_ASSERT_NEXT(a_one_bin_at_a_time, in_valid && in_ready, !in_ready, "bin accepted while busy")
  `SFOD_ASSERT_NOW(a_div_done_in_div, div_rsp.done, state == S_DIV, "divider finished outside wait")
  `SFOD_ASSERT_NOW(a_strength_range, out_valid, onset_strength <= ONE_Q15, "strength above one")
endmodule
